[hw/rtl/scan_to_polygon_points_assert.svh]
// ----------------------------------------------------------------------------
// scan_to_polygon_points_assert.svh
// Assertion macros for the scan-to-polygon RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SCAN_TO_POLYGON_POINTS_ASSERT_SVH
`define SCAN_TO_POLYGON_POINTS_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, quiet during reset
`define SCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scp: assertion failed");
// next-cycle implication
`define SCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scp: assertion failed");
`else
`define SCP_ASSERT_IMP(lbl, ante, cons)
`define SCP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, register indexes and CORDIC constants.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 17;
  localparam int TRIG_W    = 32;
  localparam int Z_W       = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_END     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OCCLUSION_GAP = 3'd4;

  localparam logic [CFG_W-1:0] ANGLE_STEP_RST = 16'd182;
  localparam logic [CFG_W-1:0] RANGE_LIMIT_RST = 16'hFFFF;
  localparam logic [CFG_W-1:0] OCCL_GAP_RST = 16'd1000;

  // 0.607252935 * 2^30
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURN32 [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [1:0] {
    JOB_LEAD_IN,
    JOB_SAMPLE,
    JOB_LEAD_OUT
  } job_t;

  typedef enum logic [1:0] {
    PT_LEAD_IN,
    PT_SAMPLE,
    PT_LEAD_OUT,
    PT_CLOSE
  } pt_t;

  typedef struct packed {
    logic valid;
    job_t job;
    logic last;
    logic kind;
  } job_ctl_t;

  typedef struct packed {
    logic valid;
    pt_t  pt;
    logic lor;
    logic kind;
  } pt_ctl_t;

endpackage

[hw/rtl/scp_in_if.sv]
// ----------------------------------------------------------------------------
// scp_in_if
// Range sample channel: valid/ready with one sample per beat.
// ----------------------------------------------------------------------------
interface scp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        first_sample;
  logic        last_sample;

  modport source (output valid, range_mm, first_sample, last_sample, input ready);
  modport sink   (input valid, range_mm, first_sample, last_sample, output ready);
endinterface

[hw/rtl/scp_out_if.sv]
// ----------------------------------------------------------------------------
// scp_out_if
// Polygon point channel: valid/ready with one point per beat.
// ----------------------------------------------------------------------------
interface scp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [scp_pkg::COORD_W-1:0]  point_x;
  logic signed [scp_pkg::COORD_W-1:0]  point_y;
  logic                                point_kind;
  logic                                last_of_run;
  logic                                polygon_end;

  modport source (output valid, point_x, point_y, point_kind, last_of_run, polygon_end,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_kind, last_of_run, polygon_end,
                  output ready);
endinterface

[hw/rtl/scp_cordic_cell.sv]
// ----------------------------------------------------------------------------
// scp_cordic_cell
// One CORDIC rotation stage; registers its result and the job riding along.
// ----------------------------------------------------------------------------
module scp_cordic_cell #(
  parameter int STAGE = 0,
  parameter int RW    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  scp_pkg::job_ctl_t                   i_ctl,
  input  logic                                i_flip,
  input  logic [RW-1:0]                       i_range,
  input  logic signed [scp_pkg::TRIG_W-1:0]   i_x,
  input  logic signed [scp_pkg::TRIG_W-1:0]   i_y,
  input  logic signed [scp_pkg::Z_W-1:0]      i_z,
  output scp_pkg::job_ctl_t                   o_ctl,
  output logic                                o_flip,
  output logic [RW-1:0]                       o_range,
  output logic signed [scp_pkg::TRIG_W-1:0]   o_x,
  output logic signed [scp_pkg::TRIG_W-1:0]   o_y,
  output logic signed [scp_pkg::Z_W-1:0]      o_z
);

  localparam logic signed [scp_pkg::Z_W-1:0] ATAN_STEP =
    scp_pkg::Z_W'(scp_pkg::ATAN_TURN32[STAGE]);

  scp_pkg::job_ctl_t                 ctl_r;
  logic                              flip_r;
  logic [RW-1:0]                     range_r;
  logic signed [scp_pkg::TRIG_W-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [scp_pkg::Z_W-1:0]    z_r, z_nxt;

  assign dx = i_y >>> STAGE;
  assign dy = i_x >>> STAGE;

  // rotate toward zero residual angle
  always_comb begin
    if (!i_z[scp_pkg::Z_W-1]) begin
      x_nxt = i_x - dx;
      y_nxt = i_y + dy;
      z_nxt = i_z - ATAN_STEP;
    end else begin
      x_nxt = i_x + dx;
      y_nxt = i_y - dy;
      z_nxt = i_z + ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (adv) begin
      ctl_r   <= i_ctl;
      flip_r  <= i_flip;
      range_r <= i_range;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
    end
  end

  assign o_ctl   = ctl_r;
  assign o_flip  = flip_r;
  assign o_range = range_r;
  assign o_x     = x_r;
  assign o_y     = y_r;
  assign o_z     = z_r;

endmodule

[hw/rtl/scp_scale_lane.sv]
// ----------------------------------------------------------------------------
// scp_scale_lane
// Four-stage scaler for one coordinate: range * trig, rounded, divided by
// the lead count where asked, saturated to +-65535. Also gives half range.
// ----------------------------------------------------------------------------
module scp_scale_lane #(
  parameter int RW          = 16,
  parameter int LEAD_POINTS = 5
) (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic [RW-1:0]                        range_i,
  input  logic signed [scp_pkg::TRIG_W-1:0]    trig_i,
  input  logic [$clog2((LEAD_POINTS > 1) ? LEAD_POINTS : 2)-1:0] num_i,
  input  logic                                 sel_lead_i,
  output logic signed [scp_pkg::COORD_W-1:0]   main_o,
  output logic signed [scp_pkg::COORD_W-1:0]   half_o
);

  localparam int NB   = $clog2((LEAD_POINTS > 1) ? LEAD_POINTS : 2);
  localparam int PW   = RW + 33;
  localparam int MAGW = RW + 32;
  localparam int LSW  = MAGW + NB + 1;
  localparam int TW   = RW + NB + 3;
  localparam int FW   = RW + 3;
  localparam int HW   = RW + 2;
  localparam logic [LSW-1:0] LEAD_BIAS = LSW'(LEAD_POINTS) << 29;
  localparam logic [TW-1:0]  RECIP     = TW'((64'd1 << TW) / LEAD_POINTS);
  localparam logic [TW-1:0]  LEAD_DEN  = TW'(LEAD_POINTS);

  // stage 1: product
  logic signed [PW-1:0] pa, pb, p1_r;
  logic [NB-1:0]        num1_r;
  logic                 sel1_r;

  assign pa = PW'($signed({1'b0, range_i}));
  assign pb = PW'(trig_i);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= pa * pb;
      num1_r <= num_i;
      sel1_r <= sel_lead_i;
    end
  end

  // stage 2: magnitude, rounding for full, half and lead fractions
  logic                 neg1;
  logic [PW-1:0]        abs1;
  logic [MAGW-1:0]      mag1;
  logic [LSW-1:0]       lsum;
  logic [MAGW:0]        fsum, hsum;
  logic [FW-1:0]        fq;
  logic [HW-1:0]        hq;
  logic                 neg2_r, sel2_r;
  logic [TW-1:0]        t2_r;
  logic [15:0]          full2_r, half2_r;

  assign neg1 = p1_r[PW-1];
  assign abs1 = neg1 ? PW'(-p1_r) : PW'(p1_r);
  assign mag1 = abs1[MAGW-1:0];
  assign lsum = LSW'(mag1) * LSW'(num1_r) + LEAD_BIAS;
  assign fsum = (MAGW+1)'(mag1) + (MAGW+1)'(64'd1 << 29);
  assign hsum = (MAGW+1)'(mag1) + (MAGW+1)'(64'd1 << 30);
  assign fq   = FW'(fsum >> 30);
  assign hq   = HW'(hsum >> 31);

  always_ff @(posedge clk) begin
    if (adv) begin
      neg2_r  <= neg1;
      sel2_r  <= sel1_r;
      t2_r    <= TW'(lsum >> 30);
      full2_r <= (fq > FW'(17'd65535)) ? 16'hFFFF : 16'(fq);
      half2_r <= (hq > HW'(17'd65535)) ? 16'hFFFF : 16'(hq);
    end
  end

  // stage 3: reciprocal multiply for the division by the lead count
  logic [2*TW-1:0] prod3_r;
  logic [TW-1:0]   t3_r;
  logic            neg3_r, sel3_r;
  logic [15:0]     full3_r, half3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod3_r <= (2*TW)'(t2_r) * (2*TW)'(RECIP);
      t3_r    <= t2_r;
      neg3_r  <= neg2_r;
      sel3_r  <= sel2_r;
      full3_r <= full2_r;
      half3_r <= half2_r;
    end
  end

  // stage 4: correct the quotient by one, saturate, apply sign
  logic [TW-1:0]  q0, qm, rem, qc;
  logic [15:0]    lead16, main16;
  logic signed [scp_pkg::COORD_W-1:0] main_r, half_r;

  assign q0     = TW'(prod3_r >> TW);
  assign qm     = TW'(q0 * LEAD_DEN);
  assign rem    = t3_r - qm;
  assign qc     = (rem >= LEAD_DEN) ? TW'(q0 + 1'b1) : q0;
  assign lead16 = (qc > TW'(17'd65535)) ? 16'hFFFF : 16'(qc);
  assign main16 = sel3_r ? lead16 : full3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      main_r <= neg3_r ? -scp_pkg::COORD_W'(main16) : scp_pkg::COORD_W'(main16);
      half_r <= neg3_r ? -scp_pkg::COORD_W'(half3_r) : scp_pkg::COORD_W'(half3_r);
    end
  end

  assign main_o = main_r;
  assign half_o = half_r;

endmodule

[hw/rtl/scan_to_polygon_points.sv]
// ----------------------------------------------------------------------------
// scan_to_polygon_points
// Path: hold register, CORDIC cells, expander, scaler stages and output register.
// Throughput: one CORDIC job per cycle through the cell chain unless the expander
//   stalls; a plain sample gives one point, two with an occlusion point; a first
//   sample adds LEAD_POINTS points, a last LEAD_POINTS + 1, via the one-point port.
// Reset: synchronous, active low; registers take their reset values and the
//   sample index and previous point clear to zero.
// ----------------------------------------------------------------------------
`include "scan_to_polygon_points_assert.svh"

module scan_to_polygon_points #(
  parameter int LEAD_POINTS   = 5,
  parameter int RANGE_BITS    = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  scp_in_if.sink                          in_ch,
  scp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [scp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scp_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int RW        = RANGE_BITS;
  localparam int AW        = ANGLE_BITS;
  localparam int NB        = $clog2((LEAD_POINTS > 1) ? LEAD_POINTS : 2);
  localparam int CW        = $clog2(LEAD_POINTS + 1);
  localparam int CMPW      = (RW > 16) ? RW : 16;
  localparam int TW        = scp_pkg::TRIG_W;
  localparam int CO        = scp_pkg::COORD_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] angle_start_r, angle_step_r, angle_end_r, range_limit_r, occl_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r <= '0;
      angle_step_r  <= scp_pkg::ANGLE_STEP_RST;
      angle_end_r   <= '0;
      range_limit_r <= scp_pkg::RANGE_LIMIT_RST;
      occl_gap_r    <= scp_pkg::OCCL_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scp_pkg::CFG_ANGLE_START:   angle_start_r <= cfg_wdata;
        scp_pkg::CFG_ANGLE_STEP:    angle_step_r  <= cfg_wdata;
        scp_pkg::CFG_ANGLE_END:     angle_end_r   <= cfg_wdata;
        scp_pkg::CFG_RANGE_LIMIT:   range_limit_r <= cfg_wdata;
        scp_pkg::CFG_OCCLUSION_GAP: occl_gap_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Issue: hold one accepted sample and split it into CORDIC jobs
  // (lead-in angle if first, sample angle, lead-out angle if last).
  // --------------------------------------------------------------------------
  logic                 hold_v_r, hold_first_r, hold_last_r;
  logic [RW-1:0]        hold_range_r;
  scp_pkg::job_t        ph_r;
  logic [15:0]          idx_r, theta_idx;
  logic                 cadv, iss_final, in_fire;
  logic [AW-1:0]        start_a, step_a, end_a, idx_a, theta_a, ang;
  logic [31:0]          a32, a_rot, a_fold;
  logic                 flip0;

  assign iss_final   = (ph_r == scp_pkg::JOB_LEAD_OUT) ||
                       ((ph_r == scp_pkg::JOB_SAMPLE) && !hold_last_r);
  assign in_ch.ready = !hold_v_r || (cadv && iss_final);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // index restarts at zero on a first sample
  assign theta_idx = hold_first_r ? '0 : idx_r;
  assign start_a   = AW'($signed(angle_start_r));
  assign step_a    = AW'($signed(angle_step_r));
  assign end_a     = AW'($signed(angle_end_r));
  assign idx_a     = AW'(theta_idx);
  assign theta_a   = start_a + AW'(idx_a * step_a);

  always_comb begin
    case (ph_r)
      scp_pkg::JOB_LEAD_IN:  ang = start_a;
      scp_pkg::JOB_LEAD_OUT: ang = end_a;
      default:               ang = theta_a;
    endcase
  end

  // widen to 2^32 per turn, fold the left half-plane by a half turn
  assign a32    = {ang, {(32-AW){1'b0}}};
  assign a_rot  = a32 + 32'h4000_0000;
  assign flip0  = a_rot[31];
  assign a_fold = flip0 ? (a32 + 32'h8000_0000) : a32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      ph_r     <= scp_pkg::JOB_SAMPLE;
      idx_r    <= '0;
    end else begin
      if (hold_v_r && cadv) begin
        if (ph_r == scp_pkg::JOB_SAMPLE) begin
          idx_r <= hold_last_r ? '0 : 16'(theta_idx + 16'd1);
        end
        if (iss_final) begin
          hold_v_r <= 1'b0;
        end else if (ph_r == scp_pkg::JOB_LEAD_IN) begin
          ph_r <= scp_pkg::JOB_SAMPLE;
        end else begin
          ph_r <= scp_pkg::JOB_LEAD_OUT;
        end
      end
      if (in_fire) begin
        hold_v_r     <= 1'b1;
        hold_range_r <= RW'(in_ch.range_mm);
        hold_first_r <= in_ch.first_sample;
        hold_last_r  <= in_ch.last_sample;
        ph_r         <= in_ch.first_sample ? scp_pkg::JOB_LEAD_IN : scp_pkg::JOB_SAMPLE;
      end
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC chain: one cell per rotation stage, advancing together
  // --------------------------------------------------------------------------
  scp_pkg::job_ctl_t                ch_ctl   [CORDIC_STAGES+1];
  logic                             ch_flip  [CORDIC_STAGES+1];
  logic [RW-1:0]                    ch_range [CORDIC_STAGES+1];
  logic signed [TW-1:0]             ch_x     [CORDIC_STAGES+1];
  logic signed [TW-1:0]             ch_y     [CORDIC_STAGES+1];
  logic signed [scp_pkg::Z_W-1:0]   ch_z     [CORDIC_STAGES+1];

  assign ch_ctl[0].valid = hold_v_r;
  assign ch_ctl[0].job   = ph_r;
  assign ch_ctl[0].last  = hold_last_r;
  assign ch_ctl[0].kind  = CMPW'(hold_range_r) >= CMPW'(range_limit_r);
  assign ch_flip[0]      = flip0;
  assign ch_range[0]     = hold_range_r;
  assign ch_x[0]         = scp_pkg::CORDIC_GAIN;
  assign ch_y[0]         = '0;
  assign ch_z[0]         = scp_pkg::Z_W'($signed(a_fold));

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    scp_cordic_cell #(
      .STAGE (k),
      .RW    (RW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (cadv),
      .i_ctl   (ch_ctl[k]),
      .i_flip  (ch_flip[k]),
      .i_range (ch_range[k]),
      .i_x     (ch_x[k]),
      .i_y     (ch_y[k]),
      .i_z     (ch_z[k]),
      .o_ctl   (ch_ctl[k+1]),
      .o_flip  (ch_flip[k+1]),
      .o_range (ch_range[k+1]),
      .o_x     (ch_x[k+1]),
      .o_y     (ch_y[k+1]),
      .o_z     (ch_z[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Expander: turn one job into its point requests; when the scaler is not stalled, one per cycle
  // --------------------------------------------------------------------------
  logic                 exp_v_r, exp_last_r, exp_kind_r;
  scp_pkg::job_t        exp_job_r;
  logic [RW-1:0]        exp_range_r;
  logic signed [TW-1:0] exp_c_r, exp_s_r;
  logic [CW-1:0]        exp_cnt_r;
  logic                 exp_done, exp_take, sadv;
  scp_pkg::pt_ctl_t     rq;
  logic [NB-1:0]        rq_num;

  always_comb begin
    rq.valid = exp_v_r;
    rq.kind  = exp_kind_r;
    rq.lor   = 1'b0;
    rq_num   = NB'(exp_cnt_r);
    case (exp_job_r)
      scp_pkg::JOB_LEAD_IN: begin
        rq.pt    = scp_pkg::PT_LEAD_IN;
        exp_done = (exp_cnt_r == CW'(LEAD_POINTS - 1));
      end
      scp_pkg::JOB_LEAD_OUT: begin
        rq_num   = NB'(CW'(LEAD_POINTS - 1) - exp_cnt_r);
        exp_done = (exp_cnt_r == CW'(LEAD_POINTS));
        // the step after the lead-out points closes the polygon
        rq.pt    = exp_done ? scp_pkg::PT_CLOSE : scp_pkg::PT_LEAD_OUT;
        rq.lor   = exp_done;
      end
      default: begin
        rq.pt    = scp_pkg::PT_SAMPLE;
        rq.lor   = !exp_last_r;
        exp_done = 1'b1;
      end
    endcase
  end

  assign exp_take = !exp_v_r || (sadv && exp_done);
  assign cadv     = !ch_ctl[CORDIC_STAGES].valid || exp_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_v_r   <= 1'b0;
      exp_cnt_r <= '0;
    end else if (exp_take) begin
      exp_v_r     <= ch_ctl[CORDIC_STAGES].valid;
      exp_cnt_r   <= '0;
      exp_job_r   <= ch_ctl[CORDIC_STAGES].job;
      exp_last_r  <= ch_ctl[CORDIC_STAGES].last;
      exp_kind_r  <= ch_ctl[CORDIC_STAGES].kind;
      exp_range_r <= ch_range[CORDIC_STAGES];
      // undo the half-turn fold
      exp_c_r <= ch_flip[CORDIC_STAGES] ? -ch_x[CORDIC_STAGES] : ch_x[CORDIC_STAGES];
      exp_s_r <= ch_flip[CORDIC_STAGES] ? -ch_y[CORDIC_STAGES] : ch_y[CORDIC_STAGES];
    end else if (sadv && exp_v_r) begin
      exp_cnt_r <= exp_cnt_r + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Scaler: x and y lanes with matching control stages
  // --------------------------------------------------------------------------
  scp_pkg::pt_ctl_t     pc1_r, pc2_r, pc3_r, pc4_r;
  logic                 sel_lead;
  logic signed [CO-1:0] sx, sy, hx, hy;

  assign sel_lead = (rq.pt == scp_pkg::PT_LEAD_IN) || (rq.pt == scp_pkg::PT_LEAD_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc1_r <= '0;
      pc2_r <= '0;
      pc3_r <= '0;
      pc4_r <= '0;
    end else if (sadv) begin
      pc1_r <= rq;
      pc2_r <= pc1_r;
      pc3_r <= pc2_r;
      pc4_r <= pc3_r;
    end
  end

  scp_scale_lane #(.RW(RW), .LEAD_POINTS(LEAD_POINTS)) u_lane_x (
    .clk        (clk),
    .adv        (sadv),
    .range_i    (exp_range_r),
    .trig_i     (exp_c_r),
    .num_i      (rq_num),
    .sel_lead_i (sel_lead),
    .main_o     (sx),
    .half_o     (hx)
  );

  scp_scale_lane #(.RW(RW), .LEAD_POINTS(LEAD_POINTS)) u_lane_y (
    .clk        (clk),
    .adv        (sadv),
    .range_i    (exp_range_r),
    .trig_i     (exp_s_r),
    .num_i      (rq_num),
    .sel_lead_i (sel_lead),
    .main_o     (sy),
    .half_o     (hy)
  );

  // --------------------------------------------------------------------------
  // Output stage: occlusion test against the previous point, then one beat
  // per point. A sample that jumps sends its half-range point first and
  // holds the scaler until that point is registered.
  // --------------------------------------------------------------------------
  logic                 out_v_r, okind_r, olor_r, opend_r, mid_done_r;
  logic signed [CO-1:0] ox_r, oy_r, prev_x_r, prev_y_r;
  logic signed [CO:0]   dxd, dyd;
  logic [CO:0]          dxa, dya;
  logic                 need_mid, out_free, s4_take;

  assign dxd      = (CO+1)'(prev_x_r) - (CO+1)'(sx);
  assign dyd      = (CO+1)'(prev_y_r) - (CO+1)'(sy);
  assign dxa      = dxd[CO] ? (CO+1)'(-dxd) : (CO+1)'(dxd);
  assign dya      = dyd[CO] ? (CO+1)'(-dyd) : (CO+1)'(dyd);
  assign need_mid = pc4_r.valid && (pc4_r.pt == scp_pkg::PT_SAMPLE) &&
                    ((dxa > (CO+1)'(occl_gap_r)) || (dya > (CO+1)'(occl_gap_r)));
  assign out_free = !out_v_r || out_ch.ready;
  assign s4_take  = pc4_r.valid && out_free && (!need_mid || mid_done_r);
  assign sadv     = !pc4_r.valid || s4_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r    <= 1'b0;
      mid_done_r <= 1'b0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
    end else if (out_free) begin
      if (pc4_r.valid) begin
        out_v_r <= 1'b1;
        if (need_mid && !mid_done_r) begin
          ox_r       <= hx;
          oy_r       <= hy;
          okind_r    <= 1'b1;
          olor_r     <= 1'b0;
          opend_r    <= 1'b0;
          mid_done_r <= 1'b1;
        end else begin
          mid_done_r <= 1'b0;
          ox_r       <= sx;
          oy_r       <= sy;
          okind_r    <= 1'b1;
          olor_r     <= 1'b0;
          opend_r    <= 1'b0;
          unique case (pc4_r.pt)
            scp_pkg::PT_LEAD_IN: begin
              prev_x_r <= sx;
              prev_y_r <= sy;
            end
            scp_pkg::PT_SAMPLE: begin
              okind_r  <= pc4_r.kind;
              olor_r   <= pc4_r.lor;
              prev_x_r <= sx;
              prev_y_r <= sy;
            end
            scp_pkg::PT_CLOSE: begin
              ox_r     <= '0;
              oy_r     <= '0;
              olor_r   <= 1'b1;
              opend_r  <= 1'b1;
              prev_x_r <= '0;
              prev_y_r <= '0;
            end
            default: ;
          endcase
        end
      end else begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.point_x     = ox_r;
  assign out_ch.point_y     = oy_r;
  assign out_ch.point_kind  = okind_r;
  assign out_ch.last_of_run = olor_r;
  assign out_ch.polygon_end = opend_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SCP_ASSERT_IMP(a_close_flags, out_v_r && opend_r, olor_r && okind_r)
  `SCP_ASSERT_IMP(a_mid_holds_sample, mid_done_r,
                  pc4_r.valid && (pc4_r.pt == scp_pkg::PT_SAMPLE))
  `SCP_ASSERT_NXT(a_idx_clear_on_last,
                  hold_v_r && cadv && (ph_r == scp_pkg::JOB_SAMPLE) && hold_last_r,
                  idx_r == 16'd0)
  `SCP_ASSERT_IMP(a_exp_cnt_bound, exp_v_r, exp_cnt_r <= CW'(LEAD_POINTS))

endmodule

[tb/sv/scan_to_polygon_points_tb.sv]
// ----------------------------------------------------------------------------
// scan_to_polygon_points_tb
// Drives range samples into the scan-to-polygon block and checks every
// emitted point against a bit-exact predictor of the CORDIC and scaling.
// ----------------------------------------------------------------------------
module scan_to_polygon_points_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEADS  = 5;
  localparam int STAGES = 16;
  localparam longint COORD_LIM = 65535;

  typedef struct {
    logic [16:0] px;
    logic [16:0] py;
    logic        kind;
    logic        lor;
    logic        pend;
  } point_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [scp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [scp_pkg::CFG_W-1:0] cfg_wdata;

  scp_in_if  in_ch ();
  scp_out_if out_ch ();

  scan_to_polygon_points DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state and register shadows
  logic [15:0] r_start, r_step, r_end, r_limit, r_gap;
  logic [15:0] scan_idx;
  longint      last_x, last_y;

  point_t expected_points[$];
  int     fail_count;
  int     hold_off;      // long receiver stall requested by a test

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  // cos and sin in Q30 for a 16-bit binary angle
  function automatic void cordic(input logic [15:0] theta, output longint c,
                                 output longint s);
    logic [31:0] a;
    logic flip;
    longint x, y, z, dx, dy;
    a = {theta, 16'h0};
    flip = a[31] ^ a[30];
    x = scp_pkg::CORDIC_GAIN;
    y = 0;
    if (flip) a = a + 32'h8000_0000;
    z = longint'(signed'(a));
    for (int i = 0; i < STAGES; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(scp_pkg::ATAN_TURN32[i]);
      end else begin
        x += dx; y -= dy; z += longint'(scp_pkg::ATAN_TURN32[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // round half away from zero, then saturate
  function automatic longint scale(longint rng, longint num, longint den, longint trig);
    longint p, d, mag, q;
    p = rng * num * trig;
    d = den << 30;
    mag = p < 0 ? -p : p;
    q = (mag + d / 2) / d;
    if (q > COORD_LIM) q = COORD_LIM;
    return p < 0 ? -q : q;
  endfunction

  function automatic void push_point(longint x, longint y, logic kind, logic pend);
    point_t p;
    p.px = x[16:0];
    p.py = y[16:0];
    p.kind = kind;
    p.lor = 1'b0;
    p.pend = pend;
    expected_points = {expected_points, p};
  endfunction

  function automatic void predict_points(logic [15:0] rng, logic first, logic last);
    longint c, s, x, y, ddx, ddy;
    logic [15:0] theta;
    if (first) begin
      scan_idx = '0;
      cordic(r_start, c, s);
      for (int i = 0; i < LEADS; i++) begin
        last_x = scale(rng, i, LEADS, c);
        last_y = scale(rng, i, LEADS, s);
        push_point(last_x, last_y, 1'b1, 1'b0);
      end
    end
    theta = r_start + scan_idx * r_step;
    cordic(theta, c, s);
    x = scale(rng, 1, 1, c);
    y = scale(rng, 1, 1, s);
    ddx = last_x - x;
    ddy = last_y - y;
    if (ddx < 0) ddx = -ddx;
    if (ddy < 0) ddy = -ddy;
    // occlusion: frontier point at half range
    if (ddx > r_gap || ddy > r_gap)
      push_point(scale(rng, 1, 2, c), scale(rng, 1, 2, s), 1'b1, 1'b0);
    push_point(x, y, rng >= r_limit, 1'b0);
    last_x = x;
    last_y = y;
    scan_idx = scan_idx + 16'd1;
    if (last) begin
      cordic(r_end, c, s);
      for (int i = 0; i < LEADS; i++)
        push_point(scale(rng, LEADS - 1 - i, LEADS, c),
                   scale(rng, LEADS - 1 - i, LEADS, s), 1'b1, 1'b0);
      push_point(0, 0, 1'b1, 1'b1);
      scan_idx = '0;
      last_x = 0;
      last_y = 0;
    end
    expected_points[$].lor = 1'b1;
  endfunction

  // checker: one point per beat, with random stalls and requested hold-off
  initial begin
    int stall;
    point_t e;
    out_ch.ready = 1'b0;
    fail_count = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (expected_points.size() == 0) begin
        $error("unexpected point x=%0d y=%0d", out_ch.point_x, out_ch.point_y);
        fail_count++;
      end else begin
        e = expected_points.pop_front();
        if (out_ch.point_x !== e.px) begin
          $error("point_x exp %0d got %0d", signed'(e.px), out_ch.point_x); fail_count++;
        end
        if (out_ch.point_y !== e.py) begin
          $error("point_y exp %0d got %0d", signed'(e.py), out_ch.point_y); fail_count++;
        end
        if (out_ch.point_kind !== e.kind) begin
          $error("point_kind exp %0b got %0b", e.kind, out_ch.point_kind); fail_count++;
        end
        if (out_ch.last_of_run !== e.lor) begin
          $error("last_of_run exp %0b got %0b", e.lor, out_ch.last_of_run); fail_count++;
        end
        if (out_ch.polygon_end !== e.pend) begin
          $error("polygon_end exp %0b got %0b", e.pend, out_ch.polygon_end); fail_count++;
        end
      end
    end
  end

  // send one sample beat; predict at acceptance, keep valid up for the next call
  task automatic send_sample(logic [15:0] rng, logic first, logic last, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.range_mm <= rng;
    in_ch.first_sample <= first;
    in_ch.last_sample <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_points(rng, first, last);
  endtask

  // drop valid, wait for all points, then let the pipeline drain
  task automatic drain_points();
    in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (STAGES + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic [scp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      scp_pkg::CFG_ANGLE_START:   r_start = val;
      scp_pkg::CFG_ANGLE_STEP:    r_step = val;
      scp_pkg::CFG_ANGLE_END:     r_end = val;
      scp_pkg::CFG_RANGE_LIMIT:   r_limit = val;
      scp_pkg::CFG_OCCLUSION_GAP: r_gap = val;
      default: ;
    endcase
  endtask

  task automatic random_range(output logic [15:0] rng);
    case ($urandom_range(0, 5))
      0: rng = 16'($urandom_range(0, 255));
      1: rng = 16'hFFFF - 16'($urandom_range(0, 3));
      default: rng = 16'($urandom);
    endcase
  endtask

  // directed: extremes of range, the lone first+last sample, defaults
  task automatic test_directed_extremes();
    send_sample(16'd0, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'h8000, 1'b0, 1'b0);
    send_sample(16'h7FFF, 1'b0, 1'b1);
    send_sample(16'hFFFF, 1'b1, 1'b1);
    send_sample(16'd1, 1'b1, 1'b1);
    // no first mark: index carries on from zero after a closed scan
    send_sample(16'd5000, 1'b0, 1'b0);
    send_sample(16'd5000, 1'b0, 1'b0);
    send_sample(16'hAAAA, 1'b0, 1'b0);
    send_sample(16'h5555, 1'b0, 1'b1);
    drain_points();
  endtask

  // walk register extremes with short scans
  task automatic test_register_extremes();
    logic [15:0] vals [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
    foreach (vals[k]) begin
      write_reg(scp_pkg::CFG_ANGLE_START, vals[k]);
      write_reg(scp_pkg::CFG_ANGLE_STEP, vals[(k + 1) % 4]);
      write_reg(scp_pkg::CFG_ANGLE_END, vals[(k + 2) % 4]);
      write_reg(scp_pkg::CFG_RANGE_LIMIT, vals[(k + 3) % 4]);
      write_reg(scp_pkg::CFG_OCCLUSION_GAP, vals[k]);
      send_sample(16'd0, 1'b1, 1'b0);
      send_sample(16'hFFFF, 1'b0, 1'b0);
      send_sample(16'd3000, 1'b0, 1'b1);
      drain_points();
    end
  endtask

  // receiver holds off while the sender keeps offering samples
  task automatic test_backpressure();
    hold_off = 300;
    send_sample(16'd4000, 1'b1, 1'b0, 1);
    for (int i = 0; i < 30; i++) send_sample(16'($urandom), 1'b0, i == 29, 1);
    drain_points();
  endtask

  // random scans, mostly well formed, some missing marks
  task automatic test_random_scans();
    int sent;
    int len;
    logic [15:0] rng;
    sent = 0;
    while (sent < 100) begin
      if ($urandom_range(0, 5) == 0) begin
        write_reg(scp_pkg::CFG_ANGLE_START, 16'($urandom));
        write_reg(scp_pkg::CFG_ANGLE_STEP,
                  16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 400)));
        write_reg(scp_pkg::CFG_ANGLE_END, 16'($urandom));
        write_reg(scp_pkg::CFG_RANGE_LIMIT, 16'($urandom));
        write_reg(scp_pkg::CFG_OCCLUSION_GAP,
                  16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000)));
      end
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        random_range(rng);
        send_sample(rng, (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0),
                    (i == len - 1) ? ($urandom_range(0, 7) != 0) : 1'b0);
        sent++;
      end
      drain_points();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.range_mm = '0;
    in_ch.first_sample = 1'b0;
    in_ch.last_sample = 1'b0;
    hold_off = 0;
    r_start = '0;
    r_step = scp_pkg::ANGLE_STEP_RST;
    r_end = '0;
    r_limit = scp_pkg::RANGE_LIMIT_RST;
    r_gap = scp_pkg::OCCL_GAP_RST;
    scan_idx = '0;
    last_x = 0;
    last_y = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_register_extremes();
    test_backpressure();
    test_random_scans();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
